// ----- hdl/synth_voice_allocator_macros.svh -----
// ---------------------------------------------------------------------------
// Voice allocator assertion macros
// Concurrent check macros; they expand to nothing in synthesis builds.
// ---------------------------------------------------------------------------
`ifndef SYNTH_VOICE_ALLOCATOR_MACROS_SVH
`define SYNTH_VOICE_ALLOCATOR_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define SVA_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("voice allocator: same-cycle check failed");

// next-cycle implication
`define SVA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("voice allocator: next-cycle check failed");

`else

`define SVA_ASSERT_IMP(label, clk, rst, ante, cons)
`define SVA_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// ----- hdl/sva_pkg.sv -----
// ---------------------------------------------------------------------------
// Voice allocator package
// Widths, codes, voice record and inter-module structs.
// ---------------------------------------------------------------------------
package sva_pkg;

   localparam int VOICE_SLOTS = 16;
   localparam int SLOT_W      = $clog2(VOICE_SLOTS);
   localparam int COUNT_W     = ($clog2(VOICE_SLOTS + 1) > 5) ? $clog2(VOICE_SLOTS + 1) : 5;

   localparam int MODE_W       = 3;
   localparam int CHANNEL_W    = 5;
   localparam int NOTE_W       = 7;
   localparam int Q15_W        = 16;
   localparam int AGE_W        = 32;
   localparam int SLOT_OUT_W   = 4;
   localparam int COUNT_OUT_W  = 5;
   localparam int LIMIT_CODE_W = 2;
   localparam int CSR_INDEX_W  = 4;
   localparam int CSR_DATA_W   = 16;

   localparam logic [SLOT_W-1:0]       LAST_SLOT  = SLOT_W'(VOICE_SLOTS - 1);
   localparam logic [Q15_W-1:0]        Q15_ONE    = 16'h8000;
   localparam logic [AGE_W-1:0]        AGE_MAX    = '1;
   localparam logic [CSR_INDEX_W-1:0]  CSR_VOICE_LIMIT  = 4'd0;
   localparam logic [CSR_INDEX_W-1:0]  CSR_RELEASE_STEP = 4'd1;
   localparam logic [LIMIT_CODE_W-1:0] LIMIT_CODE_RESET = 2'd3;
   localparam logic [Q15_W-1:0]        RELEASE_STEP_RESET = 16'd256;

   typedef enum logic [1:0] {
      STAGE_OFF     = 2'd0,
      STAGE_SUSTAIN = 2'd1,
      STAGE_RELEASE = 2'd2
   } stage_type;

   typedef enum logic [MODE_W-1:0] {
      MODE_NOTE_ON       = 3'd0,
      MODE_NOTE_OFF      = 3'd1,
      MODE_ALL_NOTES_OFF = 3'd2,
      MODE_ALL_SOUND_OFF = 3'd3,
      MODE_FRAME_TICK    = 3'd4
   } mode_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_CHECK,
      ST_ASSIGN,
      ST_OP,
      ST_FINAL,
      ST_DONE
   } state_type;

   typedef struct packed {
      stage_type              stage;
      logic [CHANNEL_W-1:0]   channel;
      logic [NOTE_W-1:0]      note;
      logic [Q15_W-1:0]       velocity;
      logic [Q15_W-1:0]       envelope;
      logic [AGE_W-1:0]       age;
   } voice_type;

   typedef struct packed {
      logic [MODE_W-1:0]      mode;
      logic [CHANNEL_W-1:0]   channel;
      logic [NOTE_W-1:0]      note;
      logic [Q15_W-1:0]       velocity;
   } req_type;

   typedef struct packed {
      logic                   active;
      logic                   release_stage;
      logic                   match;
      logic                   chan_match;
      logic                   older;
      logic                   env_end;
      logic                   step_live;
      logic [Q15_W-1:0]       env_next;
      logic [Q15_W-1:0]       vel_clamp;
   } alu_res_type;

   typedef struct packed {
      logic                   en;
      logic [SLOT_W-1:0]      idx;
      voice_type              voice;
   } wr_type;

   typedef struct packed {
      logic [SLOT_OUT_W-1:0]  voice_slot;
      logic                   slot_valid;
      logic                   stole_voice;
      logic [COUNT_OUT_W-1:0] active_count;
      logic                   note_active;
   } result_type;

endpackage

// ----- hdl/sva_if.sv -----
// ---------------------------------------------------------------------------
// Voice allocator channel interfaces
// Request, response and register-write channels with valid/ready handshake.
// ---------------------------------------------------------------------------
interface sva_req_if import sva_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [MODE_W-1:0]    mode;
   logic [CHANNEL_W-1:0] channel;
   logic [NOTE_W-1:0]    note;
   logic [Q15_W-1:0]     velocity;

   modport source (output valid, mode, channel, note, velocity, input ready);
   modport sink   (input valid, mode, channel, note, velocity, output ready);
endinterface

interface sva_rsp_if import sva_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [SLOT_OUT_W-1:0]  voice_slot;
   logic                   slot_valid;
   logic                   stole_voice;
   logic [COUNT_OUT_W-1:0] active_count;
   logic                   note_active;

   modport source (output valid, voice_slot, slot_valid, stole_voice, active_count,
                   note_active, input ready);
   modport sink   (input valid, voice_slot, slot_valid, stole_voice, active_count,
                   note_active, output ready);
endinterface

interface sva_csr_if import sva_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] index;
   logic [CSR_DATA_W-1:0]  data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ----- hdl/sva_voice_table.sv -----
// ---------------------------------------------------------------------------
// Voice table
// One record per voice in flip-flops; one read and one write address.
// ---------------------------------------------------------------------------
module sva_voice_table import sva_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic [SLOT_W-1:0] rd_idx,
   output voice_type         rd_voice,
   input  wr_type            wr
);

   voice_type voices_ff [VOICE_SLOTS];

   // reset only marks every voice inactive; payload is rewritten on use
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < VOICE_SLOTS; i++) begin
            voices_ff[i].stage <= STAGE_OFF;
         end
      end else if (wr.en) begin
         voices_ff[wr.idx] <= wr.voice;
      end
   end

   assign rd_voice = voices_ff[rd_idx];

endmodule

// ----- hdl/sva_voice_alu.sv -----
// ---------------------------------------------------------------------------
// Voice compare unit
// Shared match, age compare and envelope subtract for the scanned voice.
// ---------------------------------------------------------------------------
module sva_voice_alu import sva_pkg::*; (
   input  voice_type         voice,
   input  req_type           req,
   input  logic              best_found,
   input  logic [AGE_W-1:0]  best_age,
   input  logic [Q15_W-1:0]  release_step,
   output alu_res_type       res
);

   logic active;

   assign active = (voice.stage != STAGE_OFF);

   always_comb begin
      res.active        = active;
      res.release_stage = (voice.stage == STAGE_RELEASE);
      res.match         = active && (voice.channel == req.channel) && (voice.note == req.note);
      // channel zero addresses every channel
      res.chan_match    = active && ((req.channel == '0) || (voice.channel == req.channel));
      // strict compare keeps the lowest index on equal ages
      res.older         = active && (!best_found || (voice.age < best_age));
      res.env_end       = (voice.envelope <= release_step);
      res.step_live     = (release_step != '0);
      res.env_next      = voice.envelope - release_step;
      res.vel_clamp     = (req.velocity > Q15_ONE) ? Q15_ONE : req.velocity;
   end

endmodule

// ----- hdl/sva_sequencer.sv -----
// ---------------------------------------------------------------------------
// Voice allocator sequencer
// Walks the voice table one entry a cycle: scan, evict, apply, recount.
// ---------------------------------------------------------------------------
module sva_sequencer import sva_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_fire,
   input  req_type                 req_data,
   input  logic [LIMIT_CODE_W-1:0] limit_code,
   input  logic                    out_free,
   input  voice_type               rd_voice,
   input  alu_res_type             alu,
   output logic [SLOT_W-1:0]       rd_idx,
   output wr_type                  wr,
   output req_type                 req_q,
   output logic                    best_found,
   output logic [AGE_W-1:0]        best_age,
   output logic                    busy,
   output logic                    done,
   output result_type              result
);

   state_type state_ff, state_in;

   logic [SLOT_W-1:0]  idx_ff, idx_in;
   req_type            req_ff, req_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic               old_found_ff, old_found_in;
   logic [SLOT_W-1:0]  old_idx_ff, old_idx_in;
   logic [AGE_W-1:0]   old_age_ff, old_age_in;
   logic               free_found_ff, free_found_in;
   logic [SLOT_W-1:0]  free_idx_ff, free_idx_in;
   logic               match_found_ff, match_found_in;
   logic [SLOT_W-1:0]  match_idx_ff, match_idx_in;
   logic [AGE_W-1:0]   age_ctr_ff, age_ctr_in;
   logic [SLOT_W-1:0]  slot_ff, slot_in;
   logic               slot_valid_ff, slot_valid_in;
   logic               stole_ff, stole_in;

   logic [COUNT_W-1:0] limit;
   logic               last;
   logic               use_free;

   assign limit    = COUNT_W'(2) << limit_code;
   assign last     = (idx_ff == LAST_SLOT);
   assign use_free = (count_ff < limit) && free_found_ff;

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         age_ctr_ff <= '0;
      end else begin
         state_ff   <= state_in;
         age_ctr_ff <= age_ctr_in;
      end
   end

   // scan accumulators and request copy
   always_ff @(posedge clock) begin
      idx_ff         <= idx_in;
      req_ff         <= req_in;
      count_ff       <= count_in;
      old_found_ff   <= old_found_in;
      old_idx_ff     <= old_idx_in;
      old_age_ff     <= old_age_in;
      free_found_ff  <= free_found_in;
      free_idx_ff    <= free_idx_in;
      match_found_ff <= match_found_in;
      match_idx_ff   <= match_idx_in;
      slot_ff        <= slot_in;
      slot_valid_ff  <= slot_valid_in;
      stole_ff       <= stole_in;
   end

   // next state and table writes
   always_comb begin
      voice_type upd;

      state_in       = state_ff;
      idx_in         = idx_ff;
      req_in         = req_ff;
      count_in       = count_ff;
      old_found_in   = old_found_ff;
      old_idx_in     = old_idx_ff;
      old_age_in     = old_age_ff;
      free_found_in  = free_found_ff;
      free_idx_in    = free_idx_ff;
      match_found_in = match_found_ff;
      match_idx_in   = match_idx_ff;
      age_ctr_in     = age_ctr_ff;
      slot_in        = slot_ff;
      slot_valid_in  = slot_valid_ff;
      stole_in       = stole_ff;
      wr             = '0;
      done           = 1'b0;
      upd            = rd_voice;

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               req_in         = req_data;
               idx_in         = '0;
               count_in       = '0;
               old_found_in   = 1'b0;
               free_found_in  = 1'b0;
               match_found_in = 1'b0;
               slot_in        = '0;
               slot_valid_in  = 1'b0;
               stole_in       = 1'b0;
               state_in       = ST_SCAN;
            end
         end

         // count, oldest, first free and first match in one pass
         ST_SCAN: begin
            if (alu.active) begin
               count_in = count_ff + COUNT_W'(1);
            end
            if (alu.older) begin
               old_found_in = 1'b1;
               old_idx_in   = idx_ff;
               old_age_in   = rd_voice.age;
            end
            if (!alu.active && !free_found_ff) begin
               free_found_in = 1'b1;
               free_idx_in   = idx_ff;
            end
            if (alu.match && !match_found_ff) begin
               match_found_in = 1'b1;
               match_idx_in   = idx_ff;
            end
            idx_in = idx_ff + SLOT_W'(1);
            if (last) begin
               idx_in   = '0;
               state_in = ST_CHECK;
            end
         end

         // drop the oldest voice while over the limit, else dispatch
         ST_CHECK: begin
            if (count_ff > limit) begin
               wr.en          = 1'b1;
               wr.idx         = old_idx_ff;
               wr.voice       = '0;
               count_in       = '0;
               old_found_in   = 1'b0;
               free_found_in  = 1'b0;
               match_found_in = 1'b0;
               state_in       = ST_SCAN;
            end else begin
               case (mode_type'(req_ff.mode))
                  MODE_NOTE_ON: begin
                     state_in = (req_ff.velocity != '0) ? ST_ASSIGN : ST_OP;
                  end
                  MODE_NOTE_OFF, MODE_ALL_NOTES_OFF, MODE_ALL_SOUND_OFF,
                  MODE_FRAME_TICK: begin
                     state_in = ST_OP;
                  end
                  default: begin
                     count_in       = '0;
                     match_found_in = 1'b0;
                     state_in       = ST_FINAL;
                  end
               endcase
            end
         end

         // reuse, then free slot under the limit, then steal the oldest
         ST_ASSIGN: begin
            wr.en = 1'b1;
            if (match_found_ff) begin
               wr.idx = match_idx_ff;
            end else if (use_free) begin
               wr.idx = free_idx_ff;
            end else if (old_found_ff) begin
               wr.idx   = old_idx_ff;
               stole_in = 1'b1;
            end else begin
               wr.idx = '0;
            end
            age_ctr_in = (age_ctr_ff == AGE_MAX) ? age_ctr_ff : age_ctr_ff + AGE_W'(1);
            wr.voice.stage    = STAGE_SUSTAIN;
            wr.voice.channel  = req_ff.channel;
            wr.voice.note     = req_ff.note;
            wr.voice.velocity = alu.vel_clamp;
            wr.voice.envelope = Q15_ONE;
            wr.voice.age      = age_ctr_in;
            slot_in        = wr.idx;
            slot_valid_in  = 1'b1;
            count_in       = '0;
            match_found_in = 1'b0;
            state_in       = ST_FINAL;
         end

         // per-voice update pass
         ST_OP: begin
            wr.idx = idx_ff;
            case (mode_type'(req_ff.mode))
               MODE_NOTE_ON, MODE_NOTE_OFF: begin
                  upd.stage = STAGE_RELEASE;
                  wr.en     = alu.match;
                  wr.voice  = upd;
               end
               MODE_ALL_NOTES_OFF: begin
                  upd.stage = STAGE_RELEASE;
                  wr.en     = alu.chan_match;
                  wr.voice  = upd;
               end
               MODE_ALL_SOUND_OFF: begin
                  wr.en    = 1'b1;
                  wr.voice = '0;
               end
               MODE_FRAME_TICK: begin
                  upd.envelope = alu.env_next;
                  wr.en        = alu.release_stage && alu.step_live;
                  wr.voice     = alu.env_end ? voice_type'('0) : upd;
               end
               default: begin
                  wr.en = 1'b0;
               end
            endcase
            idx_in = idx_ff + SLOT_W'(1);
            if (last) begin
               idx_in         = '0;
               count_in       = '0;
               match_found_in = 1'b0;
               state_in       = ST_FINAL;
            end
         end

         // recount and look up the request's note afterwards
         ST_FINAL: begin
            if (alu.active) begin
               count_in = count_ff + COUNT_W'(1);
            end
            if (alu.match) begin
               match_found_in = 1'b1;
            end
            idx_in = idx_ff + SLOT_W'(1);
            if (last) begin
               idx_in   = '0;
               state_in = ST_DONE;
            end
         end

         ST_DONE: begin
            if (out_free) begin
               done     = 1'b1;
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rd_idx     = idx_ff;
   assign req_q      = req_ff;
   assign best_found = old_found_ff;
   assign best_age   = old_age_ff;
   assign busy       = (state_ff != ST_IDLE);

   assign result.voice_slot   = SLOT_OUT_W'(slot_ff);
   assign result.slot_valid   = slot_valid_ff;
   assign result.stole_voice  = stole_ff;
   assign result.active_count = COUNT_OUT_W'(count_ff);
   assign result.note_active  = match_found_ff;

endmodule

// ----- hdl/synth_voice_allocator.sv -----
// ---------------------------------------------------------------------------
// Polyphonic voice allocator
// Voice table with note reuse, free-voice allocation and oldest-voice steal.
// ---------------------------------------------------------------------------
// One request is handled at a time, walking the 16-entry voice table one entry
// per cycle through a single read port and one shared compare/subtract unit.
// A note on with non-zero velocity scans the table, assigns a voice and
// recounts; note on with zero velocity, note off, all notes off, all sound off
// and frame tick scan, update each voice in a separate pass and recount; an
// unknown mode scans and recounts. Each voice dropped after the voice limit has
// been lowered adds another scan. A new request is taken while the previous
// response still waits in the output register. Register writes are taken at
// any time but are meant for idle periods only.
// ---------------------------------------------------------------------------
`include "synth_voice_allocator_macros.svh"

module synth_voice_allocator import sva_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   sva_req_if.sink   req_bus,
   sva_rsp_if.source rsp_bus,
   sva_csr_if.sink   csr_bus
);

   logic [LIMIT_CODE_W-1:0] limit_code_ff;
   logic [Q15_W-1:0]        release_step_ff;
   logic                    rsp_valid_ff, rsp_valid_in;
   result_type              rsp_ff, rsp_in;

   logic        req_fire;
   req_type     req_data;
   req_type     req_q;
   logic        busy;
   logic        done;
   logic        out_free;
   result_type  result;
   logic [SLOT_W-1:0] rd_idx;
   voice_type   rd_voice;
   wr_type      wr;
   alu_res_type alu;
   logic        best_found;
   logic [AGE_W-1:0] best_age;

   // request channel
   assign req_bus.ready     = !busy;
   assign req_fire          = req_bus.valid && req_bus.ready;
   assign req_data.mode     = req_bus.mode;
   assign req_data.channel  = req_bus.channel;
   assign req_data.note     = req_bus.note;
   assign req_data.velocity = req_bus.velocity;

   // register writes
   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_code_ff   <= LIMIT_CODE_RESET;
         release_step_ff <= RELEASE_STEP_RESET;
      end else if (csr_bus.valid && csr_bus.ready) begin
         if (csr_bus.index == CSR_VOICE_LIMIT) begin
            limit_code_ff <= csr_bus.data[LIMIT_CODE_W-1:0];
         end else if (csr_bus.index == CSR_RELEASE_STEP) begin
            release_step_ff <= csr_bus.data[Q15_W-1:0];
         end
      end
   end

   // response output register
   assign out_free = !rsp_valid_ff || rsp_bus.ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (done) begin
         rsp_valid_in = 1'b1;
         rsp_in       = result;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.voice_slot   = rsp_ff.voice_slot;
   assign rsp_bus.slot_valid   = rsp_ff.slot_valid;
   assign rsp_bus.stole_voice  = rsp_ff.stole_voice;
   assign rsp_bus.active_count = rsp_ff.active_count;
   assign rsp_bus.note_active  = rsp_ff.note_active;

   sva_voice_table u_table (
      .clock    (clock),
      .reset    (reset),
      .rd_idx   (rd_idx),
      .rd_voice (rd_voice),
      .wr       (wr)
   );

   sva_voice_alu u_alu (
      .voice        (rd_voice),
      .req          (req_q),
      .best_found   (best_found),
      .best_age     (best_age),
      .release_step (release_step_ff),
      .res          (alu)
   );

   sva_sequencer u_seq (
      .clock      (clock),
      .reset      (reset),
      .req_fire   (req_fire),
      .req_data   (req_data),
      .limit_code (limit_code_ff),
      .out_free   (out_free),
      .rd_voice   (rd_voice),
      .alu        (alu),
      .rd_idx     (rd_idx),
      .wr         (wr),
      .req_q      (req_q),
      .best_found (best_found),
      .best_age   (best_age),
      .busy       (busy),
      .done       (done),
      .result     (result)
   );

   // checks
   `SVA_ASSERT_IMP(a_steal_has_slot, clock, reset,
                   rsp_bus.valid && rsp_bus.stole_voice, rsp_bus.slot_valid)
   `SVA_ASSERT_IMP(a_assigned_note_active, clock, reset,
                   rsp_bus.valid && rsp_bus.slot_valid, rsp_bus.note_active)
   `SVA_ASSERT_NEXT(a_accept_goes_busy, clock, reset, req_fire, busy)
   `SVA_ASSERT_NEXT(a_done_loads_output, clock, reset, done, rsp_bus.valid && !busy)

endmodule
